[sv/regular_polygon_vertex_generator_assert.svh]
// Assertion macros for the regular polygon vertex generator.
// Needs signals clk and rst_n in the scope of each use.
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_ASSERT_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPVG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rpvg assertion failed");
`define RPVG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rpvg assertion failed");
`else
`define RPVG_ASSERT(lbl, prop)
`define RPVG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[sv/rpvg_pkg.sv]
// Shared types, constants and tables for the regular polygon vertex generator.
// No dependencies.
package rpvg_pkg;

  localparam int COORD_W  = 24;
  localparam int ANGLE_W  = 16;
  localparam int N_W      = 7;
  localparam int K_W      = 6;
  localparam int MAX_SIDES = 64;
  localparam int DP_W     = 36;
  localparam int Z_W      = 34;
  localparam int RAD_W    = 25;
  localparam int GUARD    = 8;
  localparam int STEP_W   = 5;
  localparam int DIV_STEPS = 17;
  localparam int CORDIC_STEPS = 16;
  localparam logic [29:0] INV_GAIN = 30'd652032874;

  localparam logic [2:0] ADDR_MODE  = 3'd0;
  localparam logic [2:0] ADDR_SIDES = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_VEC, S_MUL0, S_MUL1, S_MUL2,
    S_RAD, S_XLOAD, S_ROTI, S_ROT, S_EMIT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       prep;
    logic       div_step;
    logic       vec_step;
    logic       mul0;
    logic       mul1;
    logic       mul2;
    logic       mul_pass;
    logic       rad_load;
    logic       x0_load;
    logic       rot_init;
    logic       rot_step;
    logic       advance;
    logic       load_out;
    logic [STEP_W-1:0] step;
  } cmd_t;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:  r = 32'h20000000;
      4'd1:  r = 32'h12E4051E;
      4'd2:  r = 32'h09FB385B;
      4'd3:  r = 32'h051111D4;
      4'd4:  r = 32'h028B0D43;
      4'd5:  r = 32'h0145D7E1;
      4'd6:  r = 32'h00A2F61E;
      4'd7:  r = 32'h00517C55;
      4'd8:  r = 32'h0028BE53;
      4'd9:  r = 32'h00145F2F;
      4'd10: r = 32'h000A2F98;
      4'd11: r = 32'h000517CC;
      4'd12: r = 32'h00028BE6;
      4'd13: r = 32'h000145F3;
      4'd14: r = 32'h0000A2FA;
      4'd15: r = 32'h0000517D;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [N_W-1:0] n_eff(input logic [N_W-1:0] sc);
    logic [N_W-1:0] r;
    if (sc == '0) r = N_W'(1);
    else if (sc > N_W'(MAX_SIDES)) r = N_W'(MAX_SIDES);
    else r = sc;
    return r;
  endfunction

endpackage

[sv/rpvg_dp.sv]
// Datapath: centre, divider, CORDIC vectoring and rotation, gain multiplier.
// Depends on rpvg_pkg; driven by rpvg_ctrl commands.
module rpvg_dp (
  input  logic                                 clk,
  input  rpvg_pkg::cmd_t                       cmd,
  input  logic                                 center_mode,
  input  logic [rpvg_pkg::N_W-1:0]             n,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  start_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  start_y,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  end_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  end_y,
  output logic signed [rpvg_pkg::COORD_W-1:0]  vertex_x,
  output logic signed [rpvg_pkg::COORD_W-1:0]  vertex_y
);
  localparam int CW = rpvg_pkg::COORD_W;
  localparam int DW = rpvg_pkg::DP_W;
  localparam int ZW = rpvg_pkg::Z_W;
  localparam int NW = rpvg_pkg::N_W;

  logic signed [CW-1:0] cx_r, cy_r, ex_r, ey_r;
  logic signed [DW-1:0] x_r, y_r, x0_r;
  logic [31:0]          vz_r;
  logic signed [ZW-1:0] rz_r;
  logic                 zero_r, flip_r;
  logic [NW:0]          drem_r;
  logic [16:0]          dq_r;
  logic [16:0]          off_r;
  logic [NW-1:0]        orem_r;
  logic [47:0]          prod_r;
  logic [65:0]          acc_r;
  logic [rpvg_pkg::RAD_W-1:0] rad_r;
  logic [rpvg_pkg::ANGLE_W-1:0] ang_r;
  logic signed [CW-1:0] vx_r, vy_r;

  logic signed [CW:0]   sumx, sumy, dx, dy;
  logic signed [DW-1:0] dxs, dys, xsh, ysh;
  logic [31:0]          atn;
  logic [NW:0]          dtr;
  logic [DW-1:0]        mop;
  logic [DW-1:0]        mres;
  logic [DW:0]          rsum;
  logic [15:0]          a16;
  logic [31:0]          t0, t1;
  logic                 fold;
  logic signed [DW-1:0] fx, fy, rx, ry;
  logic signed [CW+4:0] px, py;
  logic [NW:0]          osum;
  logic signed [CW-1:0] satx, saty;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+4:0] v);
    logic signed [CW-1:0] r;
    if (v > $signed({{6{1'b0}}, {(CW-1){1'b1}}})) r = {1'b0, {(CW-1){1'b1}}};
    else if (v < $signed({{5{1'b1}}, 1'b1, {(CW-1){1'b0}}})) r = {1'b1, {(CW-1){1'b0}}};
    else r = v[CW-1:0];
    return r;
  endfunction

  always_comb begin
    sumx = ({start_x[CW-1], start_x} + {end_x[CW-1], end_x}) >>> 1;
    sumy = ({start_y[CW-1], start_y} + {end_y[CW-1], end_y}) >>> 1;
    dx   = {ex_r[CW-1], ex_r} - {cx_r[CW-1], cx_r};
    dy   = {ey_r[CW-1], ey_r} - {cy_r[CW-1], cy_r};
    dxs  = {{(DW-CW-1-rpvg_pkg::GUARD){dx[CW]}}, dx, {rpvg_pkg::GUARD{1'b0}}};
    dys  = {{(DW-CW-1-rpvg_pkg::GUARD){dy[CW]}}, dy, {rpvg_pkg::GUARD{1'b0}}};
    xsh  = x_r >>> cmd.step[3:0];
    ysh  = y_r >>> cmd.step[3:0];
    atn  = rpvg_pkg::atan_turn(cmd.step[3:0]);
    dtr  = {drem_r[NW-1:0], (cmd.step == '0)};
    if (cmd.mul_pass) mop = {{(DW-rpvg_pkg::RAD_W-rpvg_pkg::GUARD){1'b0}}, rad_r,
                             {rpvg_pkg::GUARD{1'b0}}};
    else if (x_r[DW-1]) mop = '0;
    else mop = x_r;
    mres = acc_r[65:30];
    rsum = {1'b0, mres} + (DW+1)'(128);
    a16  = ang_r - off_r[15:0];
    t0   = {a16, 16'h0};
    fold = t0[31] ^ t0[30];
    t1   = fold ? (t0 - 32'h80000000) : t0;
    fx   = flip_r ? -x_r : x_r;
    fy   = flip_r ? -y_r : y_r;
    rx   = (fx + DW'(128)) >>> rpvg_pkg::GUARD;
    ry   = (fy + DW'(128)) >>> rpvg_pkg::GUARD;
    px   = {{5{cx_r[CW-1]}}, cx_r} + rx[CW+4:0];
    py   = {{5{cy_r[CW-1]}}, cy_r} + ry[CW+4:0];
    satx = sat(px);
    saty = sat(py);
    osum = {1'b0, orem_r} + drem_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cx_r <= center_mode ? sumx[CW-1:0] : start_x;
      cy_r <= center_mode ? sumy[CW-1:0] : start_y;
      ex_r <= end_x;
      ey_r <= end_y;
    end
    if (cmd.prep) begin
      x_r    <= dx[CW] ? -dxs : dxs;
      y_r    <= dx[CW] ? -dys : dys;
      vz_r   <= dx[CW] ? 32'h80000000 : 32'h0;
      zero_r <= (dx == '0) && (dy == '0);
      drem_r <= '0;
      dq_r   <= '0;
      off_r  <= '0;
      orem_r <= n >> 1;
    end
    if (cmd.div_step) begin
      if (dtr >= {1'b0, n}) begin
        drem_r <= dtr - {1'b0, n};
        dq_r   <= {dq_r[15:0], 1'b1};
      end else begin
        drem_r <= dtr;
        dq_r   <= {dq_r[15:0], 1'b0};
      end
    end
    if (cmd.vec_step) begin
      if (!y_r[DW-1]) begin
        x_r <= x_r + ysh; y_r <= y_r - xsh; vz_r <= vz_r + atn;
      end else begin
        x_r <= x_r - ysh; y_r <= y_r + xsh; vz_r <= vz_r - atn;
      end
    end
    if (cmd.mul0) prod_r <= mop[17:0] * rpvg_pkg::INV_GAIN;
    if (cmd.mul1) begin
      acc_r  <= {18'h0, prod_r};
      prod_r <= mop[35:18] * rpvg_pkg::INV_GAIN;
    end
    if (cmd.mul2) acc_r <= acc_r + {prod_r, 18'h0};
    if (cmd.rad_load) begin
      if (zero_r) begin
        rad_r <= '0;
        ang_r <= '0;
      end else begin
        rad_r <= (|rsum[DW:rpvg_pkg::GUARD+rpvg_pkg::RAD_W]) ? '1 :
                 rsum[rpvg_pkg::GUARD+rpvg_pkg::RAD_W-1:rpvg_pkg::GUARD];
        ang_r <= 16'(({vz_r} + 32'h00008000) >> 16);
      end
    end
    if (cmd.x0_load) x0_r <= mres;
    if (cmd.rot_init) begin
      x_r    <= x0_r;
      y_r    <= '0;
      rz_r   <= {{(ZW-32){t1[31]}}, t1};
      flip_r <= fold;
    end
    if (cmd.rot_step) begin
      if (!rz_r[ZW-1]) begin
        x_r <= x_r - ysh; y_r <= y_r + xsh; rz_r <= rz_r - {2'b0, atn};
      end else begin
        x_r <= x_r + ysh; y_r <= y_r - xsh; rz_r <= rz_r + {2'b0, atn};
      end
    end
    if (cmd.advance) begin
      if (osum >= {1'b0, n}) begin
        orem_r <= NW'(osum - {1'b0, n});
        off_r  <= off_r + dq_r + 17'd1;
      end else begin
        orem_r <= osum[NW-1:0];
        off_r  <= off_r + dq_r;
      end
    end
    if (cmd.load_out) begin
      vx_r <= satx;
      vy_r <= saty;
    end
  end

  assign vertex_x = vx_r;
  assign vertex_y = vy_r;

endmodule

[sv/rpvg_ctrl.sv]
// Controller state machine: sequences the datapath, counts vertices, owns
// the output handshake. Depends on rpvg_pkg and the assertion header.
`include "regular_polygon_vertex_generator_assert.svh"
module rpvg_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic [rpvg_pkg::N_W-1:0]      n,
  output logic [rpvg_pkg::K_W-1:0]      vertex_index,
  output logic                          last,
  output rpvg_pkg::cmd_t                cmd
);
  localparam int SW = rpvg_pkg::STEP_W;
  localparam int KW = rpvg_pkg::K_W;

  rpvg_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          pass_r, pass_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [KW-1:0] idx_r;
  logic          last_r;
  logic          can_load, is_last;

  assign can_load = !out_valid_r || !out_stall;
  assign is_last  = ({1'b0, k_r} == (n - rpvg_pkg::N_W'(1)));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pass_nxt  = pass_r;
    k_nxt     = k_r;
    case (state_r)
      rpvg_pkg::S_IDLE:  if (in_valid) state_nxt = rpvg_pkg::S_PREP;
      rpvg_pkg::S_PREP: begin
        state_nxt = rpvg_pkg::S_DIV;
        step_nxt  = '0;
      end
      rpvg_pkg::S_DIV: begin
        if (step_r == SW'(rpvg_pkg::DIV_STEPS - 1)) begin
          state_nxt = rpvg_pkg::S_VEC;
          step_nxt  = '0;
        end else step_nxt = step_r + SW'(1);
      end
      rpvg_pkg::S_VEC: begin
        if (step_r == SW'(rpvg_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = rpvg_pkg::S_MUL0;
          pass_nxt  = 1'b0;
        end else step_nxt = step_r + SW'(1);
      end
      rpvg_pkg::S_MUL0:  state_nxt = rpvg_pkg::S_MUL1;
      rpvg_pkg::S_MUL1:  state_nxt = rpvg_pkg::S_MUL2;
      rpvg_pkg::S_MUL2:  state_nxt = pass_r ? rpvg_pkg::S_XLOAD : rpvg_pkg::S_RAD;
      rpvg_pkg::S_RAD: begin
        state_nxt = rpvg_pkg::S_MUL0;
        pass_nxt  = 1'b1;
      end
      rpvg_pkg::S_XLOAD: begin
        state_nxt = rpvg_pkg::S_ROTI;
        k_nxt     = '0;
      end
      rpvg_pkg::S_ROTI: begin
        state_nxt = rpvg_pkg::S_ROT;
        step_nxt  = '0;
      end
      rpvg_pkg::S_ROT: begin
        if (step_r == SW'(rpvg_pkg::CORDIC_STEPS - 1)) state_nxt = rpvg_pkg::S_EMIT;
        else step_nxt = step_r + SW'(1);
      end
      rpvg_pkg::S_EMIT: begin
        if (can_load) begin
          if (is_last) state_nxt = rpvg_pkg::S_IDLE;
          else begin
            state_nxt = rpvg_pkg::S_ROTI;
            k_nxt     = k_r + KW'(1);
          end
        end
      end
      default: state_nxt = rpvg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.step     = step_r;
    cmd.mul_pass = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      rpvg_pkg::S_IDLE:  cmd.load_in  = in_valid;
      rpvg_pkg::S_PREP:  cmd.prep     = 1'b1;
      rpvg_pkg::S_DIV:   cmd.div_step = 1'b1;
      rpvg_pkg::S_VEC:   cmd.vec_step = 1'b1;
      rpvg_pkg::S_MUL0:  cmd.mul0     = 1'b1;
      rpvg_pkg::S_MUL1:  cmd.mul1     = 1'b1;
      rpvg_pkg::S_MUL2:  cmd.mul2     = 1'b1;
      rpvg_pkg::S_RAD:   cmd.rad_load = 1'b1;
      rpvg_pkg::S_XLOAD: cmd.x0_load  = 1'b1;
      rpvg_pkg::S_ROTI:  cmd.rot_init = 1'b1;
      rpvg_pkg::S_ROT:   cmd.rot_step = 1'b1;
      rpvg_pkg::S_EMIT: begin
        cmd.load_out  = can_load;
        cmd.advance   = can_load && !is_last;
        if (can_load) out_valid_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpvg_pkg::S_IDLE;
      step_r      <= '0;
      pass_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      idx_r  <= k_r;
      last_r <= is_last;
    end
  end

  assign in_stall     = (state_r != rpvg_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign vertex_index = idx_r;
  assign last         = last_r;

  `RPVG_ASSERT(a_rot_to_emit, (state_r == rpvg_pkg::S_ROT) && (step_r == SW'(rpvg_pkg::CORDIC_STEPS - 1)) |=> (state_r == rpvg_pkg::S_EMIT))
  `RPVG_ASSERT(a_last_ends, cmd.load_out && is_last |=> (state_r == rpvg_pkg::S_IDLE) && last_r)
  `RPVG_ASSERT(a_load_frees, cmd.load_out |-> (!out_valid_r || !out_stall))
  `RPVG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == rpvg_pkg::S_IDLE) && !out_valid_r)

endmodule

[sv/regular_polygon_vertex_generator.sv]
// Top level of the regular polygon vertex generator: APB registers,
// controller and datapath. Depends on rpvg_pkg, rpvg_ctrl, rpvg_dp.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  start_x start_y end_x end_y
//   out_*       out  out_valid/out_stall vertex_x vertex_y vertex_index last
//   apb         in   psel/penable/pready center_mode (0x0), side_count (0x4)
//
// Each item runs a setup (17-step divider for the angle step, 16-step CORDIC
// vectoring, two gain multiplications) and then one rotation per vertex in
// the shared CORDIC rotator, with up to 64 vertices per item.
// Reset clears control state and restores center_mode 1, side_count 6.
// A stalled output holds its vertex; the next vertex waits until it is taken.
module regular_polygon_vertex_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_end_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rpvg_pkg::COORD_W-1:0]  out_vertex_x,
  output logic signed [rpvg_pkg::COORD_W-1:0]  out_vertex_y,
  output logic [rpvg_pkg::K_W-1:0]             out_vertex_index,
  output logic                                 out_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  logic                       mode_r;
  logic [rpvg_pkg::N_W-1:0]   sides_r;
  logic [rpvg_pkg::N_W-1:0]   n;
  rpvg_pkg::cmd_t             cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      sides_r <= rpvg_pkg::N_W'(6);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) sides_r <= pwdata[rpvg_pkg::N_W-1:0];
      else mode_r <= pwdata[0];
    end
  end

  always_comb begin
    case (paddr)
      rpvg_pkg::ADDR_MODE:  prdata = {31'h0, mode_r};
      rpvg_pkg::ADDR_SIDES: prdata = {{(32-rpvg_pkg::N_W){1'b0}}, sides_r};
      default:              prdata = '0;
    endcase
  end

  assign n = rpvg_pkg::n_eff(sides_r);

  rpvg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .n            (n),
    .vertex_index (out_vertex_index),
    .last         (out_last),
    .cmd          (cmd)
  );

  rpvg_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .center_mode (mode_r),
    .n           (n),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .vertex_x    (out_vertex_x),
    .vertex_y    (out_vertex_y)
  );

endmodule

[bench/rpvg_checker.sv]
`timescale 1ns / 1ps
// Vertex checker for the regular polygon vertex generator: watches the APB
// writes and both item channels, predicts every vertex and compares it.
// Depends on rpvg_pkg for widths and register addresses.
module rpvg_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  in_end_y,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  out_vertex_x,
  input  logic signed [rpvg_pkg::COORD_W-1:0]  out_vertex_y,
  input  logic [rpvg_pkg::K_W-1:0]             out_vertex_index,
  input  logic                                 out_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  input  logic                                 pready,
  output int                                   fail_count,
  output int                                   pending
);
  localparam int CW = rpvg_pkg::COORD_W;
  localparam int KW = rpvg_pkg::K_W;

  typedef struct packed {
    logic [CW-1:0] vx;
    logic [CW-1:0] vy;
    logic [KW-1:0] idx;
    logic          last;
  } vertex_t;

  localparam logic [31:0] ARCTAN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };
  localparam longint COORD_HI = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint unsigned RAD_MAX = (64'd1 << rpvg_pkg::RAD_W) - 1;

  vertex_t vertex_q[$];
  logic       mode_copy;
  logic [6:0] sides_copy;

  function automatic longint unsigned apply_gain(input longint unsigned a);
    return (a >> 30) * longint'(rpvg_pkg::INV_GAIN) +
           (((a & 64'h3FFFFFFF) * longint'(rpvg_pkg::INV_GAIN)) >> 30);
  endfunction

  function automatic longint clamp_coord(input longint v);
    return v > COORD_HI ? COORD_HI : (v < COORD_LO ? COORD_LO : v);
  endfunction

  function automatic void predict_polygon(input longint sx, input longint sy,
                                          input longint ex, input longint ey);
    longint cx, cy, dx, dy, x, y, xs, ys, zr, vx, vy, off;
    longint unsigned rad;
    logic [31:0] z, t;
    logic [15:0] ang;
    int n;
    bit flip;
    vertex_t v;
    rad = 0;
    ang = '0;
    if (mode_copy) begin
      cx = (sx + ex) >>> 1;
      cy = (sy + ey) >>> 1;
    end else begin
      cx = sx;
      cy = sy;
    end
    dx = ex - cx;
    dy = ey - cy;
    if (dx != 0 || dy != 0) begin
      x = dx * 256;
      y = dy * 256;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < rpvg_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += ARCTAN[i];
        end else begin
          x -= ys; y += xs; z -= ARCTAN[i];
        end
      end
      if (x < 0) x = 0;
      rad = (apply_gain(x) + 128) >> 8;
      if (rad > RAD_MAX) rad = RAD_MAX;
      z = z + 32'h00008000;
      ang = z[31:16];
    end
    n = sides_copy;
    if (n == 0) n = 1;
    if (n > rpvg_pkg::MAX_SIDES) n = rpvg_pkg::MAX_SIDES;
    for (int k = 0; k < n; k++) begin
      off = ((longint'(k) << 16) + n / 2) / n;
      t = {ang - off[15:0], 16'h0};
      flip = 0;
      if (((t + 32'h40000000) & 32'h80000000) != 0) begin
        t = t - 32'h80000000;
        flip = 1;
      end
      zr = int'(t);
      x = longint'(apply_gain(rad << 8));
      y = 0;
      for (int i = 0; i < rpvg_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (zr >= 0) begin
          x -= ys; y += xs; zr -= longint'(ARCTAN[i]);
        end else begin
          x += ys; y -= xs; zr += longint'(ARCTAN[i]);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      vx = clamp_coord(cx + ((x + 128) >>> 8));
      vy = clamp_coord(cy + ((y + 128) >>> 8));
      v.vx = vx[CW-1:0];
      v.vy = vy[CW-1:0];
      v.idx = k[KW-1:0];
      v.last = (k + 1 == n);
      vertex_q.push_back(v);
    end
  endfunction

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst_n) begin
      mode_copy <= 1'b1;
      sides_copy <= 7'd6;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == rpvg_pkg::ADDR_MODE) mode_copy <= pwdata[0];
        else if (paddr == rpvg_pkg::ADDR_SIDES) sides_copy <= pwdata[6:0];
      end
      if (out_valid && !out_stall) begin
        got = '{out_vertex_x, out_vertex_y, out_vertex_index, out_last};
        if (vertex_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected vertex: x=%0d y=%0d idx=%0d last=%0d",
                     out_vertex_x, out_vertex_y, out_vertex_index, out_last);
          fail_count <= fail_count + 1;
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("vertex mismatch: exp x=%0d y=%0d idx=%0d last=%0d,",
                       $signed(want.vx), $signed(want.vy), want.idx, want.last,
                       " got x=%0d y=%0d idx=%0d last=%0d",
                       out_vertex_x, out_vertex_y, out_vertex_index, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_polygon(in_start_x, in_start_y, in_end_x, in_end_y);
    end
    pending <= vertex_q.size();
  end

endmodule

[bench/tb_regular_polygon_vertex_generator.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the regular polygon vertex generator: drives
// points and APB writes under varied idling; rpvg_checker does the checking.
// Depends on rpvg_pkg, rpvg_checker and the block itself.
module tb_regular_polygon_vertex_generator;
  localparam int CW = rpvg_pkg::COORD_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_vertex_x, out_vertex_y;
  logic [rpvg_pkg::K_W-1:0] out_vertex_index;
  logic out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int send_idle = 0, stall_pct = 0;
  int hold_asked = 0, hold_done = 0, hold_left = 0;

  always #1 clk = ~clk;

  regular_polygon_vertex_generator u_top (.*);

  rpvg_checker u_checker (.*);

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 3000;
      hold_done <= hold_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_shape(input logic mode, input logic [6:0] sides);
    drain();
    write_reg(rpvg_pkg::ADDR_MODE, {31'd0, mode});
    write_reg(rpvg_pkg::ADDR_SIDES, {25'd0, sides});
  endtask

  task automatic send_points(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                             input logic [CW-1:0] ex, input logic [CW-1:0] ey);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic send_random();
    logic [CW-1:0] sx, sy;
    if ($urandom_range(2) == 0) begin
      send_points(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
    end else begin
      sx = CW'($urandom);
      sy = CW'($urandom);
      send_points(sx, sy, sx + CW'($urandom_range(8000) - 4000),
                  sy + CW'($urandom_range(8000) - 4000));
    end
  endtask

  function automatic logic [6:0] pick_sides();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      3: return 7'($urandom_range(9, 20));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_shape(1'b1, 7'd6);
    send_points(24'd1000, 24'd2000, 24'd1000, 24'd2000);
    send_points(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
    send_points(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    send_points(24'h800000, 24'h000000, 24'h7FFFFF, 24'h000000);
    send_points(24'd0, 24'd0, -24'sd512, 24'd0);
    send_points(24'd0, 24'd0, 24'd0, -24'sd512);
    send_points(24'd0, 24'd0, 24'd0, 24'd1);
    set_shape(1'b0, 7'd3);
    send_points(24'd5, -24'sd7, 24'd5, -24'sd7);
    send_points(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    send_points(24'h7FFFFF, 24'h000000, 24'h800000, 24'h7FFFFF);
    send_points(24'd0, 24'd0, 24'd256, 24'd256);
    send_points(24'd0, 24'd0, -24'sd256, 24'd256);
    set_shape(1'b0, 7'd0);
    send_points(24'd100, 24'd100, 24'd900, -24'sd300);
    send_points(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    set_shape(1'b1, 7'd127);
    send_points(24'd0, 24'd0, 24'd2560, 24'd0);
    set_shape(1'b0, 7'd64);
    send_points(24'h7FFF00, 24'h800100, 24'h800000, 24'h7FFFFF);
    set_shape(1'b1, 7'd1);
    send_points(-24'sd3000, 24'd4000, 24'd3000, -24'sd4000);
    send_points(24'd1, 24'd1, 24'd2, 24'd2);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 84; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 84; end
        default: begin send_idle = 21; stall_pct = 21; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        set_shape(1'($urandom), pick_sides());
        for (int i = 0; i < 12; i++) begin
          if (phase == 0 && seg == 1 && i == 2) hold_asked++;
          if (phase == 3 && seg == 1 && i == 6) drain();
          send_random();
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
